// File: rtl/ftvd_pkg.sv
// Shared constants, types and hash function for the vertex dedup block.
package ftvd_pkg;
  localparam int MAX_VERTICES = 4096;
  localparam int REF_BITS = 20;
  localparam int IDX_BITS = $clog2(MAX_VERTICES);
  localparam int TOT_BITS = IDX_BITS + 1;
  localparam int SLOT_BITS = IDX_BITS + 1;
  localparam int CFG_BITS = 21;
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_POSITION_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_UV_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NORMAL_COUNT = 2'd2;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic op;
    logic face_start;
    logic [REF_BITS-1:0] p;
    logic [REF_BITS-1:0] u;
    logic [REF_BITS-1:0] n;
  } word_t;

  typedef struct packed {
    logic [1:0] status;
    logic new_vertex;
    logic [IDX_BITS-1:0] vertex_index;
    logic tri_valid;
    logic [IDX_BITS-1:0] tri_first;
    logic [IDX_BITS-1:0] tri_prev;
    logic [IDX_BITS-1:0] tri_curr;
    logic [REF_BITS-1:0] fetch_position;
    logic [REF_BITS-1:0] fetch_uv;
    logic [REF_BITS-1:0] fetch_normal;
    logic [2:0] attr_valid;
  } result_t;

  // Word after the multiply stage: three products still to be combined.
  typedef struct packed {
    logic [31:0] hp;
    logic [31:0] hu;
    logic [31:0] hn;
  } prod_t;

  function automatic logic [SLOT_BITS-1:0] hash_fold(prod_t pr);
    logic [31:0] h;
    h = pr.hp ^ pr.hu ^ pr.hn;
    h = h ^ (h >> 15);
    return h[SLOT_BITS-1:0];
  endfunction
endpackage

// File: rtl/ftvd_front.sv
// Front end: takes words, multiplies the hash terms and queues them.
module ftvd_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ftvd_pkg::word_t push_word,
  output logic full,
  input  logic pop,
  output logic avail,
  output ftvd_pkg::word_t head_word,
  output logic [ftvd_pkg::SLOT_BITS-1:0] head_slot
);
  import ftvd_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  logic stage_valid;
  word_t stage_word;
  prod_t stage_prod;
  word_t q_word [QUEUE_DEPTH];
  logic [SLOT_BITS-1:0] q_slot [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0] count;
  logic q_push;

  assign q_push = stage_valid;
  // stage plus queue never exceed the queue depth
  assign full = (count + {{PTR_BITS{1'b0}}, stage_valid}) >= (PTR_BITS+1)'(QUEUE_DEPTH);
  assign avail = count != '0;
  assign head_word = q_word[rd_ptr];
  assign head_slot = q_slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      stage_valid <= push;
      if (q_push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{PTR_BITS{1'b0}}, q_push} - {{PTR_BITS{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stage_word <= push_word;
      stage_prod.hp <= 32'(push_word.p) * 32'd2654435761;
      stage_prod.hu <= 32'(push_word.u) * 32'd2246822519;
      stage_prod.hn <= 32'(push_word.n) * 32'd3266489917;
    end
    if (q_push) begin
      q_word[wr_ptr] <= stage_word;
      q_slot[wr_ptr] <= hash_fold(stage_prod);
    end
  end
endmodule

// File: rtl/ftvd_back.sv
// Back end: probes the hash table, inserts vertices and builds fan triangles.
module ftvd_back (
  input  logic clk,
  input  logic rst,
  input  logic avail,
  input  ftvd_pkg::word_t head_word,
  input  logic [ftvd_pkg::SLOT_BITS-1:0] head_slot,
  output logic pop,
  input  logic [ftvd_pkg::CFG_BITS-1:0] position_count,
  input  logic [ftvd_pkg::CFG_BITS-1:0] uv_count,
  input  logic [ftvd_pkg::CFG_BITS-1:0] normal_count,
  output logic clearing,
  output logic out_valid,
  output ftvd_pkg::result_t out_result
);
  import ftvd_pkg::*;

  localparam int SLOTS = 2 * MAX_VERTICES;
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_KEY = 3'd3;
  localparam logic [2:0] S_CMP = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // slot memory: tag = vertex + 1, zero marks an empty slot
  logic [TOT_BITS-1:0] slot_mem [SLOTS];
  logic [3*REF_BITS-1:0] key_mem [MAX_VERTICES];

  logic [2:0] state;
  logic [SLOT_BITS-1:0] slot;
  logic [TOT_BITS-1:0] slot_rd;
  logic [3*REF_BITS-1:0] key_rd;
  logic clear_req;
  logic [SLOT_BITS-1:0] clr_addr;
  word_t cur;
  logic [TOT_BITS-1:0] vertex_total;
  logic [IDX_BITS-1:0] fan_first;
  logic [IDX_BITS-1:0] fan_prev;
  logic [1:0] corner;
  logic [IDX_BITS-1:0] idx;
  logic created;
  logic slot_we;
  logic [TOT_BITS-1:0] slot_wd;
  logic [SLOT_BITS-1:0] slot_wa;
  logic key_we;
  logic [TOT_BITS-1:0] tag_v;
  logic tag_live;
  logic [REF_BITS-1:0] pm1, um1, nm1;
  logic out_valid_next;
  result_t res;

  assign clearing = state == S_CLEAR;
  assign pop = state == S_IDLE && avail;
  assign tag_v = slot_rd;
  assign tag_live = tag_v != '0;
  assign pm1 = cur.p - 1'b1;
  assign um1 = cur.u - 1'b1;
  assign nm1 = cur.n - 1'b1;

  always_comb begin
    slot_we = 1'b0;
    slot_wa = slot;
    slot_wd = vertex_total + 1'b1;
    key_we = 1'b0;
    if (state == S_CLEAR) begin
      slot_we = 1'b1;
      slot_wa = clr_addr;
      slot_wd = '0;
    end else if (state == S_READ && !tag_live && vertex_total < TOT_BITS'(MAX_VERTICES)) begin
      slot_we = 1'b1;
      key_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot];
    if (key_we) key_mem[vertex_total[IDX_BITS-1:0]] <= {cur.p, cur.u, cur.n};
    key_rd <= key_mem[tag_v[IDX_BITS-1:0] - 1'b1];
  end

  always_comb begin
    res = '0;
    res.vertex_index = idx;
    if (created) begin
      res.new_vertex = 1'b1;
      if ({1'b0, pm1} < position_count) begin
        res.attr_valid[0] = 1'b1;
        res.fetch_position = pm1;
      end
      if (cur.u != '0 && {1'b0, um1} < uv_count) begin
        res.attr_valid[1] = 1'b1;
        res.fetch_uv = um1;
      end
      if (cur.n != '0 && {1'b0, nm1} < normal_count) begin
        res.attr_valid[2] = 1'b1;
        res.fetch_normal = nm1;
      end
    end
    if (corner == 2'd2) begin
      res.tri_valid = 1'b1;
      res.tri_first = fan_first;
      res.tri_prev = fan_prev;
      res.tri_curr = idx;
    end
  end

  always_comb begin
    out_valid_next = 1'b0;
    unique case (state)
      S_CLEAR: out_valid_next = clear_req && clr_addr == SLOT_BITS'(SLOTS - 1);
      S_IDLE: out_valid_next = pop && !head_word.op && head_word.p == '0;
      S_READ: out_valid_next = !tag_live && vertex_total >= TOT_BITS'(MAX_VERTICES);
      S_DONE: out_valid_next = 1'b1;
      default: out_valid_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      clear_req <= 1'b0;
      vertex_total <= '0;
      fan_first <= '0;
      fan_prev <= '0;
      corner <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_BITS'(SLOTS - 1)) begin
            clear_req <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur <= head_word;
            slot <= head_slot;
            if (head_word.op) begin
              out_result <= '0;
              vertex_total <= '0;
              fan_first <= '0;
              fan_prev <= '0;
              corner <= '0;
              clear_req <= 1'b1;
              clr_addr <= '0;
              state <= S_CLEAR;
            end else begin
              if (head_word.face_start) corner <= '0;
              if (head_word.p == '0) begin
                out_result <= '{status: ST_MISSING, default: '0};
              end else begin
                state <= S_KEY;
              end
            end
          end
        end
        S_KEY: state <= S_READ;
        S_READ: begin
          if (tag_live) begin
            state <= S_CMP;
          end else if (vertex_total >= TOT_BITS'(MAX_VERTICES)) begin
            out_result <= '{status: ST_FULL, default: '0};
            state <= S_IDLE;
          end else begin
            idx <= vertex_total[IDX_BITS-1:0];
            created <= 1'b1;
            vertex_total <= vertex_total + 1'b1;
            state <= S_DONE;
          end
        end
        S_CMP: begin
          if (key_rd == {cur.p, cur.u, cur.n}) begin
            idx <= IDX_BITS'(tag_v - 1'b1);
            created <= 1'b0;
            state <= S_DONE;
          end else begin
            slot <= slot + 1'b1;
            state <= S_KEY;
          end
        end
        S_DONE: begin
          out_result <= res;
          unique case (corner)
            2'd0: begin
              fan_first <= idx;
              corner <= 2'd1;
            end
            2'd1: begin
              fan_prev <= idx;
              corner <= 2'd2;
            end
            default: fan_prev <= idx;
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/fan_triangulate_vertex_dedup.sv
// Top level of the vertex dedup and fan triangulation block.
// Usage: drive start with op, face_start and the three one-based refs while
// busy is low; the word is taken at that edge. Each word yields exactly one
// result, shown for one cycle with done high.
// The front end registers the hash products in one stage and queues up to
// two words; a taken word passes through the product stage register and
// then the queue before it reaches the back end. Back end per corner: it
// dequeues in S_IDLE, then per probed slot runs S_KEY (address) and S_READ
// (slot read), adds S_CMP for the key compare where the slot is occupied,
// and reports in S_DONE. Missing-position words are reported from S_IDLE
// without a probe; table-full words are reported from S_READ. Words are
// taken one behind another: busy rises while two words wait in the front end.
// Reset runs a clearing pass over the 8192 hash slots; busy stays high until
// it ends. A clear word runs the same pass and reports when it ends.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at any time
// and should be made while idle.
// The receiver cannot stall: results must be captured when done is high.
module fan_triangulate_vertex_dedup (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic op,
  input  logic face_start,
  input  logic [ftvd_pkg::REF_BITS-1:0] position_ref,
  input  logic [ftvd_pkg::REF_BITS-1:0] uv_ref,
  input  logic [ftvd_pkg::REF_BITS-1:0] normal_ref,
  input  logic cfg_we,
  input  logic [ftvd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ftvd_pkg::CFG_BITS-1:0] cfg_data,
  output logic done,
  output logic [1:0] status,
  output logic new_vertex,
  output logic [ftvd_pkg::IDX_BITS-1:0] vertex_index,
  output logic tri_valid,
  output logic [ftvd_pkg::IDX_BITS-1:0] tri_first,
  output logic [ftvd_pkg::IDX_BITS-1:0] tri_prev,
  output logic [ftvd_pkg::IDX_BITS-1:0] tri_curr,
  output logic [ftvd_pkg::REF_BITS-1:0] fetch_position,
  output logic [ftvd_pkg::REF_BITS-1:0] fetch_uv,
  output logic [ftvd_pkg::REF_BITS-1:0] fetch_normal,
  output logic [2:0] attr_valid
);
  import ftvd_pkg::*;

  logic [CFG_BITS-1:0] position_count, uv_count, normal_count;
  logic full, avail, pop, clearing, push;
  word_t in_word, head_word;
  logic [SLOT_BITS-1:0] head_slot;
  result_t res;

  assign busy = full || clearing;
  assign push = start && !busy;
  assign in_word = '{op: op, face_start: face_start, p: position_ref, u: uv_ref,
                     n: normal_ref};

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      uv_count <= '0;
      normal_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POSITION_COUNT: position_count <= cfg_data;
        REG_UV_COUNT: uv_count <= cfg_data;
        REG_NORMAL_COUNT: normal_count <= cfg_data;
        default: ;
      endcase
    end
  end

  ftvd_front u_front (
    .clk(clk), .rst(rst), .push(push), .push_word(in_word), .full(full),
    .pop(pop), .avail(avail), .head_word(head_word), .head_slot(head_slot)
  );

  ftvd_back u_back (
    .clk(clk), .rst(rst), .avail(avail), .head_word(head_word),
    .head_slot(head_slot), .pop(pop), .position_count(position_count),
    .uv_count(uv_count), .normal_count(normal_count), .clearing(clearing),
    .out_valid(done), .out_result(res)
  );

  assign status = res.status;
  assign new_vertex = res.new_vertex;
  assign vertex_index = res.vertex_index;
  assign tri_valid = res.tri_valid;
  assign tri_first = res.tri_first;
  assign tri_prev = res.tri_prev;
  assign tri_curr = res.tri_curr;
  assign fetch_position = res.fetch_position;
  assign fetch_uv = res.fetch_uv;
  assign fetch_normal = res.fetch_normal;
  assign attr_valid = res.attr_valid;

  a_no_push_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !push) else $error("word taken during clear");
  a_no_done_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done) else $error("result during clear");
  a_tri_new: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> !new_vertex && !tri_valid)
    else $error("dropped word reported vertex");
endmodule

// File: verif/ftvd_checker.sv
// Checker: predicts each result of the vertex dedup block and compares it.
`timescale 1ns / 100ps
module ftvd_checker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic op,
  input  logic face_start,
  input  logic [ftvd_pkg::REF_BITS-1:0] position_ref,
  input  logic [ftvd_pkg::REF_BITS-1:0] uv_ref,
  input  logic [ftvd_pkg::REF_BITS-1:0] normal_ref,
  input  logic cfg_we,
  input  logic [ftvd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ftvd_pkg::CFG_BITS-1:0] cfg_data,
  input  logic done,
  input  logic [1:0] status,
  input  logic new_vertex,
  input  logic [ftvd_pkg::IDX_BITS-1:0] vertex_index,
  input  logic tri_valid,
  input  logic [ftvd_pkg::IDX_BITS-1:0] tri_first,
  input  logic [ftvd_pkg::IDX_BITS-1:0] tri_prev,
  input  logic [ftvd_pkg::IDX_BITS-1:0] tri_curr,
  input  logic [ftvd_pkg::REF_BITS-1:0] fetch_position,
  input  logic [ftvd_pkg::REF_BITS-1:0] fetch_uv,
  input  logic [ftvd_pkg::REF_BITS-1:0] fetch_normal,
  input  logic [2:0] attr_valid,
  output int errors,
  output int pending
);
  import ftvd_pkg::*;

  logic [CFG_BITS-1:0] pos_count, uv_count, nrm_count;
  int unsigned vertex_map [logic [3*REF_BITS-1:0]];
  int unsigned vertex_total;
  logic [IDX_BITS-1:0] fan_first, fan_prev;
  int corner_seen;
  result_t expected_results [$];

  function automatic result_t dedup_corner(logic o, logic fs, logic [REF_BITS-1:0] p,
                                           logic [REF_BITS-1:0] u, logic [REF_BITS-1:0] n);
    result_t r;
    logic [3*REF_BITS-1:0] key;
    int unsigned idx;
    r = '0;
    key = {p, u, n};
    if (o) begin
      vertex_map.delete();
      vertex_total = 0;
      fan_first = '0;
      fan_prev = '0;
      corner_seen = 0;
      return r;
    end
    if (fs) corner_seen = 0;
    if (p == 0) begin
      r.status = ST_MISSING;
      return r;
    end
    if (vertex_map.exists(key)) begin
      idx = vertex_map[key];
    end else begin
      if (vertex_total >= MAX_VERTICES) begin
        r.status = ST_FULL;
        return r;
      end
      idx = vertex_total;
      vertex_map[key] = idx;
      vertex_total++;
      r.new_vertex = 1'b1;
      if ({1'b0, p - 1'b1} < pos_count) begin
        r.attr_valid[0] = 1'b1;
        r.fetch_position = p - 1'b1;
      end
      if (u != 0 && {1'b0, u - 1'b1} < uv_count) begin
        r.attr_valid[1] = 1'b1;
        r.fetch_uv = u - 1'b1;
      end
      if (n != 0 && {1'b0, n - 1'b1} < nrm_count) begin
        r.attr_valid[2] = 1'b1;
        r.fetch_normal = n - 1'b1;
      end
    end
    r.status = ST_OK;
    r.vertex_index = idx[IDX_BITS-1:0];
    if (corner_seen == 0) begin
      fan_first = idx[IDX_BITS-1:0];
      corner_seen = 1;
    end else if (corner_seen == 1) begin
      fan_prev = idx[IDX_BITS-1:0];
      corner_seen = 2;
    end else begin
      r.tri_valid = 1'b1;
      r.tri_first = fan_first;
      r.tri_prev = fan_prev;
      r.tri_curr = idx[IDX_BITS-1:0];
      fan_prev = idx[IDX_BITS-1:0];
    end
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      pos_count <= '0;
      uv_count <= '0;
      nrm_count <= '0;
      vertex_map.delete();
      vertex_total = 0;
      fan_first = '0;
      fan_prev = '0;
      corner_seen = 0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POSITION_COUNT: pos_count <= cfg_data;
          REG_UV_COUNT: uv_count <= cfg_data;
          REG_NORMAL_COUNT: nrm_count <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        expected_results.insert(expected_results.size(),
                                dedup_corner(op, face_start, position_ref, uv_ref,
                                             normal_ref));
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no word pending", $time);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, status);
          check_field("new_vertex", e.new_vertex, new_vertex);
          check_field("vertex_index", e.vertex_index, vertex_index);
          check_field("tri_valid", e.tri_valid, tri_valid);
          check_field("tri_first", e.tri_first, tri_first);
          check_field("tri_prev", e.tri_prev, tri_prev);
          check_field("tri_curr", e.tri_curr, tri_curr);
          check_field("fetch_position", e.fetch_position, fetch_position);
          check_field("fetch_uv", e.fetch_uv, fetch_uv);
          check_field("fetch_normal", e.fetch_normal, fetch_normal);
          check_field("attr_valid", e.attr_valid, attr_valid);
        end
      end
    end
  end

endmodule

// File: verif/tb_fan_triangulate_vertex_dedup.sv
// Testbench top: drives corner words and register writes, gives the verdict.
`timescale 1ns / 100ps
module tb_fan_triangulate_vertex_dedup;
  import ftvd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = 1'b0;
  logic face_start = 1'b0;
  logic [REF_BITS-1:0] position_ref = '0, uv_ref = '0, normal_ref = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic busy, done, new_vertex, tri_valid;
  logic [1:0] status;
  logic [IDX_BITS-1:0] vertex_index, tri_first, tri_prev, tri_curr;
  logic [REF_BITS-1:0] fetch_position, fetch_uv, fetch_normal;
  logic [2:0] attr_valid;
  int errors, pending;
  bit idle_on = 1'b1;
  int face_left = 0;

  always #1 clk = ~clk;

  fan_triangulate_vertex_dedup u_dut (.*);

  ftvd_checker u_chk (.*);

  task automatic send_word(logic o, logic fs, logic [REF_BITS-1:0] p,
                           logic [REF_BITS-1:0] u, logic [REF_BITS-1:0] n);
    @(posedge clk);
    start <= 1'b1;
    op <= o;
    face_start <= fs;
    position_ref <= p;
    uv_ref <= u;
    normal_ref <= n;
    do @(negedge clk); while (busy);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(posedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_count();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 21'd1048576;
      2: return CFG_BITS'($urandom_range(1, 40));
      default: return CFG_BITS'($urandom_range(0, 1048576));
    endcase
  endfunction

  function automatic logic [REF_BITS-1:0] pick_ref(int pool, bit zero_ok);
    int r;
    r = $urandom_range(0, 19);
    if (zero_ok && r == 0) return '0;
    if (r == 1) return REF_BITS'($urandom);
    if (r == 2) return '1;
    return REF_BITS'($urandom_range(1, pool));
  endfunction

  task automatic random_corners(int count, int pool);
    bit fs;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) begin
        send_word(1'b1, 1'b0, REF_BITS'($urandom), REF_BITS'($urandom), REF_BITS'($urandom));
      end else begin
        fs = 1'b0;
        if (face_left <= 0 || $urandom_range(0, 19) == 0) begin
          fs = 1'b1;
          face_left = $urandom_range(3, 7);
        end
        face_left--;
        send_word(1'b0, fs, (($urandom_range(0, 24) == 0) ? '0 : pick_ref(pool, 1'b0)),
                  pick_ref(pool, 1'b1), pick_ref(pool, 1'b1));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_POSITION_COUNT, 21'd16);
    write_reg(REG_UV_COUNT, 21'd16);
    write_reg(REG_NORMAL_COUNT, 21'd16);
    send_word(1'b0, 1'b1, 20'd1, 20'd0, 20'd0);
    send_word(1'b0, 1'b0, 20'd16, 20'd16, 20'd16);
    send_word(1'b0, 1'b0, 20'd17, 20'd17, 20'd17);
    send_word(1'b0, 1'b0, 20'd1, 20'd0, 20'd0);
    send_word(1'b0, 1'b0, '1, '1, '1);
    send_word(1'b0, 1'b1, 20'd0, 20'd3, 20'd3);
    send_word(1'b0, 1'b0, 20'd2, 20'd1, 20'd1);
    send_word(1'b0, 1'b0, 20'd0, 20'd0, 20'd0);
    send_word(1'b0, 1'b0, 20'd16, 20'd16, 20'd16);
    send_word(1'b0, 1'b0, 20'd3, 20'd16, 20'd0);
    send_word(1'b0, 1'b1, 20'd1, 20'd0, 20'd0);
    send_word(1'b1, 1'b0, '1, '1, '1);
    send_word(1'b0, 1'b0, 20'd16, 20'd16, 20'd16);
    send_word(1'b0, 1'b1, 20'd1, 20'd0, 20'd0);
    send_word(1'b0, 1'b0, 20'd2, 20'd2, 20'd2);
    send_word(1'b0, 1'b0, 20'd4, 20'd4, 20'd4);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_POSITION_COUNT, pick_count());
      write_reg(REG_UV_COUNT, pick_count());
      write_reg(REG_NORMAL_COUNT, pick_count());
      random_corners(170, (ph % 2) ? 40 : 8);
      drain();
    end
    idle_on = 1'b0;
    write_reg(REG_POSITION_COUNT, 21'd1048576);
    send_word(1'b1, 1'b0, '0, '0, '0);
    send_word(1'b0, 1'b1, 20'd7, 20'd0, 20'd0);
    send_word(1'b0, 1'b0, 20'd9, 20'd1, 20'd0);
    send_word(1'b1, 1'b0, '0, '0, '0);
    drain();
    write_reg(REG_POSITION_COUNT, '0);
    write_reg(REG_UV_COUNT, 21'd1048576);
    write_reg(REG_NORMAL_COUNT, '0);
    random_corners(80, 12);
    drain();
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
